// ===== hdl/itoa_pkg.sv =====
package itoa_pkg;

    // Field and digit geometry
    localparam int VALUE_W  = 32;
    localparam int NIB_W    = 4;
    localparam int DIGITS   = 10;
    localparam int BCD_W    = DIGITS * NIB_W;
    localparam int CNT_W    = 5;
    localparam int LEFT_W   = 4;
    localparam int CHAR_W   = 8;

    // ASCII codes
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_UPPER = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_LOWER = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

    // Converted digits handed from the converter to the emitter
    typedef struct packed {
        logic [BCD_W-1:0] digits;
        logic             neg;
        logic             upper;
    } t_digits;

    // Map one digit to its ASCII code
    function automatic logic [CHAR_W-1:0] digit_char(input logic [NIB_W-1:0] d,
                                                     input logic upper);
        logic [CHAR_W-1:0] base;
        base = upper ? CHAR_UPPER : CHAR_LOWER;
        if (d < 4'd10) begin
            digit_char = CHAR_ZERO + {4'd0, d};
        end else begin
            digit_char = base + {4'd0, d} - 8'd10;
        end
    endfunction

endpackage

// ===== hdl/itoa_if.sv =====
// Input channel: one value to convert per transaction
interface itoa_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] value;
    logic        radix_is_hex;
    logic        is_signed;
    logic        upper_case;

    modport source (output valid, value, radix_is_hex, is_signed, upper_case, input ready);
    modport sink   (input valid, value, radix_is_hex, is_signed, upper_case, output ready);
endinterface

// Output channel: one ASCII character per transaction
interface itoa_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last_char;

    modport source (output valid, char_code, last_char, input ready);
    modport sink   (input valid, char_code, last_char, output ready);
endinterface

// ===== hdl/itoa_dabble.sv =====
module itoa_dabble (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [itoa_pkg::VALUE_W-1:0]    i_value,
    input  logic                            i_hex,
    input  logic                            i_signed,
    input  logic                            i_upper,
    output logic                            o_idle,
    output logic                            o_done,
    output itoa_pkg::t_digits               o_digits,
    input  logic                            i_take
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SHIFT = 3'b010,
        S_DONE  = 3'b100
    } t_dab_state;

    t_dab_state                       r_state;
    logic [itoa_pkg::VALUE_W-1:0]     r_bin;
    logic [itoa_pkg::BCD_W-1:0]       r_bcd;
    logic [itoa_pkg::BCD_W-1:0]       n_bcd;
    logic [itoa_pkg::CNT_W-1:0]       r_cnt;
    logic                             r_hex;
    logic                             r_neg;
    logic                             r_upper;
    logic                             w_neg;
    logic [itoa_pkg::VALUE_W-1:0]     w_mag;
    logic [itoa_pkg::BCD_W-1:0]       w_adj;

    // Take the magnitude of a negative signed value
    assign w_neg = i_signed & i_value[itoa_pkg::VALUE_W-1];
    assign w_mag = w_neg ? (~i_value + 32'd1) : i_value;

    // Add three to each decimal digit of five or more before the shift
    always_comb begin
        for (int k = 0; k < itoa_pkg::DIGITS; k++) begin
            if (!r_hex && (r_bcd[k*itoa_pkg::NIB_W +: itoa_pkg::NIB_W] >= 4'd5)) begin
                w_adj[k*itoa_pkg::NIB_W +: itoa_pkg::NIB_W] =
                    r_bcd[k*itoa_pkg::NIB_W +: itoa_pkg::NIB_W] + 4'd3;
            end else begin
                w_adj[k*itoa_pkg::NIB_W +: itoa_pkg::NIB_W] =
                    r_bcd[k*itoa_pkg::NIB_W +: itoa_pkg::NIB_W];
            end
        end
        n_bcd = {w_adj[itoa_pkg::BCD_W-2:0], r_bin[itoa_pkg::VALUE_W-1]};
    end

    // Control: load, shift one bit per cycle, hold until the emitter takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_state <= S_SHIFT;
                        r_cnt   <= '0;
                    end
                end
                S_SHIFT: begin
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'(itoa_pkg::VALUE_W - 1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (i_take) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath: binary shifts out at the top, digits shift in at the bottom
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start) begin
            r_bin   <= w_mag;
            r_bcd   <= '0;
            r_hex   <= i_hex;
            r_neg   <= w_neg;
            r_upper <= i_upper;
        end else if (r_state == S_SHIFT) begin
            r_bin <= {r_bin[itoa_pkg::VALUE_W-2:0], 1'b0};
            r_bcd <= n_bcd;
        end
    end

    assign o_idle          = (r_state == S_IDLE);
    assign o_done          = (r_state == S_DONE);
    assign o_digits.digits = r_bcd;
    assign o_digits.neg    = r_neg;
    assign o_digits.upper  = r_upper;

endmodule

// ===== hdl/itoa_emit.sv =====
module itoa_emit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  itoa_pkg::t_digits  i_digits,
    output logic               o_take,
    itoa_out_if.source         o_out
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SIGN = 4'b0010,
        S_SKIP = 4'b0100,
        S_EMIT = 4'b1000
    } t_emit_state;

    t_emit_state                      r_state;
    logic [itoa_pkg::BCD_W-1:0]       r_dig;
    logic [itoa_pkg::LEFT_W-1:0]      r_left;
    logic                             r_upper;
    logic                             r_out_valid;
    logic [itoa_pkg::CHAR_W-1:0]      r_char;
    logic                             r_last;
    logic                             w_can_load;
    logic                             w_load;
    logic [itoa_pkg::NIB_W-1:0]       w_top;

    assign w_top      = r_dig[itoa_pkg::BCD_W-1 -: itoa_pkg::NIB_W];
    assign w_can_load = !r_out_valid || o_out.ready;
    assign w_load     = w_can_load && (r_state == S_SIGN || r_state == S_EMIT);
    assign o_take     = (r_state == S_IDLE) && i_valid;

    // Sequencer: sign, drop leading zeros, then one digit per transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_state <= i_digits.neg ? S_SIGN : S_SKIP;
                    end
                end
                S_SIGN: begin
                    if (w_can_load) begin
                        r_state <= S_SKIP;
                    end
                end
                S_SKIP: begin
                    if (!(w_top == 4'd0 && r_left > 4'd1)) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_can_load && r_left == 4'd1) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Digit register: load from the converter, advance one digit at a time
    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_dig   <= i_digits.digits;
            r_left  <= 4'(itoa_pkg::DIGITS);
            r_upper <= i_digits.upper;
        end else if ((r_state == S_SKIP && w_top == 4'd0 && r_left > 4'd1)
                     || (r_state == S_EMIT && w_can_load)) begin
            r_dig  <= {r_dig[itoa_pkg::BCD_W-itoa_pkg::NIB_W-1:0], 4'd0};
            r_left <= r_left - 4'd1;
        end
    end

    // Output register: hold the character until the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            if (r_state == S_SIGN) begin
                r_char <= itoa_pkg::CHAR_MINUS;
                r_last <= 1'b0;
            end else begin
                r_char <= itoa_pkg::digit_char(w_top, r_upper);
                r_last <= (r_left == 4'd1);
            end
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.char_code = r_char;
    assign o_out.last_char = r_last;

endmodule

// ===== hdl/integer_to_ascii_converter_top.sv =====
// Channel  Dir  Payload                                          Transaction
// i_in     in   value[31:0], radix_is_hex, is_signed, upper_case valid & ready
// o_out    out  char_code[7:0], last_char                        valid & ready
//
// A value is loaded and then shifted through the bit-serial converter, one
// bit per cycle, with digit correction in every decimal lane. Emission of up
// to 11 characters overlaps with the next conversion. Reset is synchronous,
// active low, and clears all control state. A stalled output holds its
// character; the converter then waits in its done state and i_in.ready
// stays low.
module integer_to_ascii_converter_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    itoa_in_if.sink     i_in,
    itoa_out_if.source  o_out
);

    logic              w_start;
    logic              w_idle;
    logic              w_done;
    logic              w_take;
    itoa_pkg::t_digits w_digits;

    assign i_in.ready = w_idle;
    assign w_start    = i_in.valid && w_idle;

    // Bit-serial binary to digit conversion
    itoa_dabble u_dabble (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_start),
        .i_value  (i_in.value),
        .i_hex    (i_in.radix_is_hex),
        .i_signed (i_in.is_signed),
        .i_upper  (i_in.upper_case),
        .o_idle   (w_idle),
        .o_done   (w_done),
        .o_digits (w_digits),
        .i_take   (w_take)
    );

    // Character sequencing and output register
    itoa_emit u_emit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_done),
        .i_digits (w_digits),
        .o_take   (w_take),
        .o_out    (o_out)
    );

    // A new transaction starts a conversion, so input closes next cycle
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> !i_in.ready)
        else $error("input still open after a transaction");

    // Handoff frees the converter
    a_handoff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done && w_take |=> !w_done && w_idle)
        else $error("converter did not release after handoff");

    // Minus sign is never the last character
    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.char_code == itoa_pkg::CHAR_MINUS |-> !o_out.last_char)
        else $error("minus sign marked as last character");

    // Emitter only takes digits the converter has finished
    a_take_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |-> w_done)
        else $error("emitter took digits before conversion finished");

endmodule
